// File: sv/fpba_pkg.sv
// Shared types and codes of the fit-policy block allocator.
`timescale 1ns / 1ps
package fpba_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 2'd1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    localparam logic [4:0] BLOCKS_RST = 5'd16;

    typedef struct packed {
        logic        func;
        logic [3:0]  block_index;
        logic [15:0] block_size;
        logic [15:0] request_size;
    } t_in_item;

    typedef struct packed {
        logic       granted;
        logic [3:0] chosen_block;
    } t_out_item;

    typedef struct packed {
        logic [1:0] policy;
        logic [4:0] blocks_in_use;
    } t_cfg;

endpackage

// File: sv/fpba_core.sv
// Size table, scan sequencer and shared compare unit of the allocator.
`timescale 1ns / 1ps
module fpba_core
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_idle,
    output logic      o_res_vld,
    input  logic      i_res_rdy,
    output t_out_item o_res
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [SIZE_BITS-1:0] r_mem [NUM_BLOCKS];

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_addr, n_addr;
    logic [CNT_W-1:0]     r_scan_len;
    logic [SIZE_BITS-1:0] r_req;
    logic [1:0]           r_policy;
    logic                 r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [SIZE_BITS-1:0] r_rd_data;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_pick, n_pick;
    logic [SIZE_BITS-1:0] r_best, n_best;

    logic [31:0]          blk_ext;
    logic [31:0]          bsize_ext;
    logic [31:0]          req_ext;
    logic [31:0]          pick_ext;
    logic [CNT_W-1:0]     scan_len;
    logic                 start_alloc;
    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;
    logic                 fits;
    logic                 take;

    assign blk_ext   = 32'(i_item.block_index);
    assign bsize_ext = 32'(i_item.block_size);
    assign req_ext   = 32'(i_item.request_size);
    assign pick_ext  = 32'(r_pick);

    assign start_alloc = i_start && (i_item.func == FUNC_ALLOC);

    // Clamp the scan length to the table depth.
    always_comb begin
        if (32'(i_cfg.blocks_in_use) > NUM_BLOCKS) begin
            scan_len = CNT_W'(NUM_BLOCKS);
        end else begin
            scan_len = CNT_W'(i_cfg.blocks_in_use);
        end
    end

    // Shared compare unit: fit test against the request, rank against the pick.
    always_comb begin
        fits = (r_rd_data >= r_req);
        take = 1'b0;
        if (fits) begin
            if (!r_found) begin
                take = 1'b1;
            end else if (r_policy == POL_BEST) begin
                take = (r_rd_data < r_best);
            end else if (r_policy == POL_WORST) begin
                take = (r_rd_data > r_best);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_found  = r_found;
        n_pick   = r_pick;
        n_best   = r_best;
        n_rd_vld = 1'b0;
        rd_en    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start_alloc) begin
                    n_state = S_SCAN;
                    n_addr  = '0;
                    n_found = 1'b0;
                end
            end
            S_SCAN: begin
                if (r_addr != r_scan_len) begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    n_addr   = r_addr + 1'b1;
                end else begin
                    // Last compare happens this cycle.
                    n_state = S_WRITE;
                end
                if (r_rd_vld && take) begin
                    n_found = 1'b1;
                    n_pick  = r_rd_idx;
                    n_best  = r_rd_data;
                end
            end
            S_WRITE: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table writes: a load while idle, or the remainder of a granted request.
    always_comb begin
        if (r_state == S_WRITE) begin
            wr_en   = i_res_rdy && r_found;
            wr_addr = r_pick;
            wr_data = r_best - r_req;
        end else begin
            wr_en   = i_start && (i_item.func == FUNC_LOAD) && (blk_ext < NUM_BLOCKS);
            wr_addr = blk_ext[IDX_W-1:0];
            wr_data = bsize_ext[SIZE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_pick   <= n_pick;
        r_best   <= n_best;
        r_rd_idx <= r_addr[IDX_W-1:0];
        if (start_alloc) begin
            r_scan_len <= scan_len;
            r_req      <= req_ext[SIZE_BITS-1:0];
            r_policy   <= i_cfg.policy;
        end
    end

    assign o_idle    = (r_state == S_IDLE);
    assign o_res_vld = (r_state == S_WRITE);

    always_comb begin
        o_res.granted      = r_found;
        o_res.chosen_block = r_found ? pick_ext[3:0] : 4'd0;
    end

endmodule

// File: sv/fit_policy_block_allocator_unit.sv
// Top level of the fit-policy block allocator: config registers and result register.
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_in_item  (t_in_item)
//  out      output     o_out_valid / i_out_ready  o_out_item (t_out_item)
//  cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A load item leaves the core idle; ready stays high behind it.
// A request scans min(blocks_in_use, NUM_BLOCKS) table entries between accept and result,
// reading the size table one entry per cycle through its single port.
// Reset clears the policy to first fit and blocks_in_use to 16; the table is not cleared.
// A waiting result stalls only the write-back cycle of the next request.
`timescale 1ns / 1ps
module fit_policy_block_allocator_unit
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    t_cfg      r_cfg;
    logic      r_out_vld;
    t_out_item r_out_item;

    logic      core_idle;
    logic      res_vld;
    logic      res_rdy;
    t_out_item res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy        <= POL_FIRST;
            r_cfg.blocks_in_use <= BLOCKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY: r_cfg.policy        <= i_cfg_data[1:0];
                CFG_BLOCKS: r_cfg.blocks_in_use <= i_cfg_data[4:0];
                default:    ;
            endcase
        end
    end

    fpba_core #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_start   (i_in_valid && o_in_ready),
        .i_item    (i_in_item),
        .o_idle    (core_idle),
        .o_res_vld (res_vld),
        .i_res_rdy (res_rdy),
        .o_res     (res)
    );

    // Hold the result until taken; refill in the cycle it drains.
    assign res_rdy = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_rdy) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_rdy && res_vld) begin
            r_out_item <= res;
        end
    end

    assign o_in_ready  = core_idle;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.func == FUNC_ALLOC) |=> !o_in_ready)
        else $error("request accepted but core still ready");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.func == FUNC_LOAD) |=> o_in_ready)
        else $error("load item left the core busy");

    a_no_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.granted) |-> (o_out_item.chosen_block == 4'd0))
        else $error("withheld grant carries a block index");
`endif

endmodule
